// ===== design/glu_pkg.sv =====
// ----------------------------------------------------------------------------
// glu_pkg: shared types and constants for the gcd / lcm unit
// Holds the sequencer states, the divider request and response bundles and
// the fixed operand width.
// ----------------------------------------------------------------------------
package glu_pkg;

  // operand and result width
  localparam int unsigned DATA_W = 32;

  // largest positive lcm before saturation
  localparam logic [DATA_W-1:0] LCM_MAX = 32'h7FFF_FFFF;

  // operation select codes
  localparam logic OP_GCD = 1'b0;
  localparam logic OP_LCM = 1'b1;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_STEP,
    S_REM,
    S_QUO,
    S_SAT,
    S_DONE
  } state_t;

  // request into the shared divider
  typedef struct packed {
    logic              start;
    logic [DATA_W-1:0] dividend;
    logic [DATA_W-1:0] divisor;
  } div_req_t;

  // response from the shared divider
  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] quotient;
    logic [DATA_W-1:0] remainder;
  } div_rsp_t;

endpackage

// ===== design/gcd_lcm_unit.sv =====
// ----------------------------------------------------------------------------
// gcd_lcm_unit: greatest common divisor and least common multiple
// Euclid's algorithm with a truncating remainder on signed 32-bit operands,
// and a saturating lcm built from the gcd, one divide and one multiply.
//
//   channel | ports        | contents
//   --------+--------------+---------------------------------------------
//   input   | in_tdata     | first_operand [31:0], second_operand [63:32]
//           | in_tuser     | op (0 gcd, 1 lcm)
//   result  | out_tdata    | answer [31:0]
//           | out_tuser    | overflow
//
// Each remainder step uses the shared divider; gcd runs one such step per
// Euclid step (at most 46 steps on 32-bit values). lcm adds one more divide,
// |a| / gcd, whose quotient is multiplied by |b| when the divide is done,
// and one saturate state.
// One item is in work at a time; in_tready is high only while idle.
// A result waits in the output register while out_tready is low; the unit
// holds the next result until that transfer is done. Reset is synchronous.
// ----------------------------------------------------------------------------
module gcd_lcm_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // first_operand [31:0], second_operand [63:32]
  input  logic        in_tuser,   // op
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // answer [31:0]
  output logic        out_tuser   // overflow
);

  localparam int unsigned W = glu_pkg::DATA_W;

  glu_pkg::state_t   state_r, state_nxt;
  glu_pkg::div_req_t div_req;
  glu_pkg::div_rsp_t div_rsp;

  logic           op_r, op_nxt;
  logic [W-1:0]   a_r, a_nxt;     // running magnitudes for euclid
  logic [W-1:0]   b_r, b_nxt;
  logic           sa_r, sa_nxt;   // signs that travel with them
  logic           sb_r, sb_nxt;
  logic [W-1:0]   ma_r, ma_nxt;   // original operand magnitudes
  logic [W-1:0]   mb_r, mb_nxt;
  logic [2*W-1:0] prod_r, prod_nxt;
  logic [W-1:0]   res_r, res_nxt;
  logic           ovf_r, ovf_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic [W-1:0]   out_data_r, out_data_nxt;
  logic           out_user_r, out_user_nxt;

  logic [W-1:0]   in_a, in_b;
  logic [W-1:0]   in_a_mag, in_b_mag;
  logic [2*W-1:0] mul_w;

  // operand split and magnitudes
  assign in_a     = in_tdata[W-1:0];
  assign in_b     = in_tdata[2*W-1:W];
  assign in_a_mag = in_a[W-1] ? (~in_a + 1'b1) : in_a;
  assign in_b_mag = in_b[W-1] ? (~in_b + 1'b1) : in_b;

  // lcm product of quotient and second magnitude
  assign mul_w = (2*W)'(div_rsp.quotient) * (2*W)'(mb_r);

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    sa_nxt        = sa_r;
    sb_nxt        = sb_r;
    ma_nxt        = ma_r;
    mb_nxt        = mb_r;
    prod_nxt      = prod_r;
    res_nxt       = res_r;
    ovf_nxt       = ovf_r;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;
    out_valid_nxt = out_valid_r;
    div_req.start    = 1'b0;
    div_req.dividend = a_r;
    div_req.divisor  = b_r;

    // result transfer empties the output register
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      glu_pkg::S_IDLE: begin
        if (in_tvalid) begin
          op_nxt    = in_tuser;
          a_nxt     = in_a_mag;
          b_nxt     = in_b_mag;
          sa_nxt    = in_a[W-1];
          sb_nxt    = in_b[W-1];
          ma_nxt    = in_a_mag;
          mb_nxt    = in_b_mag;
          state_nxt = glu_pkg::S_STEP;
        end
      end
      glu_pkg::S_STEP: begin
        if (b_r != '0) begin
          div_req.start = 1'b1;
          state_nxt     = glu_pkg::S_REM;
        end else if (op_r == glu_pkg::OP_GCD) begin
          res_nxt   = sa_r ? (~a_r + 1'b1) : a_r;
          ovf_nxt   = 1'b0;
          state_nxt = glu_pkg::S_DONE;
        end else if (ma_r == '0 || mb_r == '0) begin
          res_nxt   = '0;
          ovf_nxt   = 1'b0;
          state_nxt = glu_pkg::S_DONE;
        end else begin
          // |a| / |gcd|
          div_req.start    = 1'b1;
          div_req.dividend = ma_r;
          div_req.divisor  = a_r;
          state_nxt        = glu_pkg::S_QUO;
        end
      end
      glu_pkg::S_REM: begin
        // (a, b) becomes (b, a rem b); the remainder keeps the dividend sign
        if (div_rsp.done) begin
          a_nxt     = b_r;
          sa_nxt    = sb_r;
          b_nxt     = div_rsp.remainder;
          sb_nxt    = sa_r;
          state_nxt = glu_pkg::S_STEP;
        end
      end
      glu_pkg::S_QUO: begin
        if (div_rsp.done) begin
          prod_nxt  = mul_w;
          state_nxt = glu_pkg::S_SAT;
        end
      end
      glu_pkg::S_SAT: begin
        if (|prod_r[2*W-1:W-1]) begin
          res_nxt = glu_pkg::LCM_MAX;
          ovf_nxt = 1'b1;
        end else begin
          res_nxt = prod_r[W-1:0];
          ovf_nxt = 1'b0;
        end
        state_nxt = glu_pkg::S_DONE;
      end
      glu_pkg::S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          out_user_nxt  = ovf_r;
          state_nxt     = glu_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = glu_pkg::S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= glu_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    sa_r       <= sa_nxt;
    sb_r       <= sb_nxt;
    ma_r       <= ma_nxt;
    mb_r       <= mb_nxt;
    prod_r     <= prod_nxt;
    res_r      <= res_nxt;
    ovf_r      <= ovf_nxt;
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
  end

  // shared divider
  glu_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign in_tready  = (state_r == glu_pkg::S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

// ===== design/glu_div.sv =====
// ----------------------------------------------------------------------------
// glu_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle. A start latches the
// operands; done pulses on the cycle that quotient and remainder are valid.
// ----------------------------------------------------------------------------
module glu_div (
  input  logic              clk,
  input  logic              rst_n,
  input  glu_pkg::div_req_t req,
  output glu_pkg::div_rsp_t rsp
);

  localparam int unsigned W = glu_pkg::DATA_W;
  localparam int unsigned CW = $clog2(W);

  logic          busy_r, busy_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [W-1:0]  num_r, num_nxt;
  logic [W-1:0]  rem_r, rem_nxt;
  logic [W-1:0]  dvs_r, dvs_nxt;
  logic          done_r, done_nxt;

  logic [W:0]    partial;
  logic [W:0]    diff;

  // shift in the next dividend bit and trial-subtract the divisor
  assign partial = {rem_r, num_r[W-1]};
  assign diff    = partial - {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    done_nxt = 1'b0;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(W - 1);
      num_nxt  = req.dividend;
      rem_nxt  = '0;
      dvs_nxt  = req.divisor;
    end else if (busy_r) begin
      // quotient bits fill the dividend register from the bottom
      if (!diff[W]) begin
        rem_nxt = diff[W-1:0];
        num_nxt = {num_r[W-2:0], 1'b1};
      end else begin
        rem_nxt = partial[W-1:0];
        num_nxt = {num_r[W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.done      = done_r;
  assign rsp.quotient  = num_r;
  assign rsp.remainder = rem_r;

endmodule
